// ===== sv/tvc_pkg.sv =====
package tvc_pkg;

   // Configuration register indexes
   localparam logic [2:0] CSR_PHASE_INC  = 3'd0;
   localparam logic [2:0] CSR_DEPTH      = 3'd1;
   localparam logic [2:0] CSR_BASE       = 3'd2;
   localparam logic [2:0] CSR_MIX        = 3'd3;
   localparam logic [2:0] CSR_ACTIVE_CH  = 3'd4;

   localparam logic [19:0] PHASE_INC_RST = 20'd71583;
   localparam logic [18:0] DEPTH_RST     = 19'd73728;
   localparam logic [19:0] BASE_RST      = 20'd184320;
   localparam logic [15:0] MIX_RST       = 16'd11469;
   localparam logic [1:0]  ACTIVE_CH_RST = 2'd2;

   localparam logic [15:0] MIX_ONE       = 16'd32768;
   localparam logic [63:0] Q30_ONE       = 64'd1073741824;
   localparam logic [63:0] HALF_PI_Q30   = 64'd1686629713;

   typedef struct packed {
      logic signed [23:0] sample_ch1;
      logic signed [23:0] sample_ch0;
   } tvc_frame_type;

   typedef struct packed {
      logic          valid;
      tvc_frame_type frame;
   } tvc_queue_type;

   typedef struct packed {
      logic clearing;
      logic pop;
   } tvc_back_status_type;

   // Q15 sine of a 32-bit angle, Taylor series in Q30; elaboration use only
   function automatic logic signed [15:0] sine_q15(input logic [31:0] u);
      logic [1:0]  quad;
      logic [63:0] r;
      logic [63:0] a;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] s;
      logic [63:0] v;
      quad = u[31:30];
      r    = {34'd0, u[29:0]};
      a    = quad[0] ? (Q30_ONE - r) : r;
      x    = (a * HALF_PI_Q30) >> 30;
      x2   = (x * x) >> 30;
      t    = Q30_ONE - x2 / 64'd110;
      t    = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
      t    = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
      t    = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
      t    = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
      s    = (x * t) >> 30;
      v    = (s + 64'd16384) >> 15;
      if (v > 64'd32767) begin
         v = 64'd32767;
      end
      return quad[1] ? -$signed(v[15:0]) : $signed(v[15:0]);
   endfunction

endpackage

// ===== sv/tvc_front.sv =====
module tvc_front import tvc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [47:0]         req_tdata,
   input  tvc_back_status_type back_status,
   output tvc_queue_type       queue_head
);

   tvc_frame_type slot_ff [2];
   logic          wr_ptr_ff;
   logic          rd_ptr_ff;
   logic [1:0]    count_ff;
   logic          push;
   logic          pop;
   logic [1:0]    count_in;

   assign req_tready = (count_ff != 2'd2) && !back_status.clearing;
   assign push       = req_tvalid && req_tready;
   assign pop        = back_status.pop && (count_ff != 2'd0);

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= tvc_frame_type'(req_tdata);
      end
   end

   assign queue_head.valid = (count_ff != 2'd0);
   assign queue_head.frame = slot_ff[rd_ptr_ff];

endmodule

// ===== sv/tvc_back.sv =====
module tvc_back import tvc_pkg::*; #(
   parameter int DELAY_DEPTH  = 4096,
   parameter int CHANNELS     = 2,
   parameter int SINE_ENTRIES = 256
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [2:0]          csr_index,
   input  logic [19:0]         csr_wdata,
   input  tvc_queue_type       queue_head,
   output tvc_back_status_type back_status,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [47:0]         rsp_tdata
);

   localparam int IW    = $clog2(DELAY_DEPTH);
   localparam int DW    = IW + 8;
   localparam int RW    = DW + 1;
   localparam int AW    = $clog2(DELAY_DEPTH * CHANNELS);
   localparam int TOTAL = DELAY_DEPTH * CHANNELS;
   localparam int SIW   = $clog2(SINE_ENTRIES);
   localparam int KPW   = 33 + SIW;

   localparam logic [RW-1:0]      SPAN   = RW'(DELAY_DEPTH * 256);
   localparam logic signed [23:0] D_MIN  = 24'sd256;
   localparam logic signed [23:0] D_MAX  = 24'((DELAY_DEPTH - 1) * 256);
   localparam logic [IW-1:0]      I_LAST = IW'(DELAY_DEPTH - 1);
   localparam logic [AW-1:0]      CH1_BASE = AW'(DELAY_DEPTH);
   localparam logic [AW:0]        CLR_LAST = (AW + 1)'(TOTAL - 1);
   localparam logic [1:0]         NCH_MAX  = 2'(CHANNELS);

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_LFO   = 4'd2;
   localparam logic [3:0] S_D0    = 4'd3;
   localparam logic [3:0] S_D1    = 4'd4;
   localparam logic [3:0] S_ADDR  = 4'd5;
   localparam logic [3:0] S_CH    = 4'd6;
   localparam logic [3:0] S_RD    = 4'd7;
   localparam logic [3:0] S_MIX1  = 4'd8;
   localparam logic [3:0] S_MIX2  = 4'd9;
   localparam logic [3:0] S_WR    = 4'd10;
   localparam logic [3:0] S_DONE  = 4'd11;

   // Configuration registers
   logic [19:0] phase_inc_ff;
   logic [18:0] depth_ff;
   logic [19:0] base_ff;
   logic [15:0] mix_ff;
   logic [1:0]  active_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_inc_ff <= PHASE_INC_RST;
         depth_ff     <= DEPTH_RST;
         base_ff      <= BASE_RST;
         mix_ff       <= MIX_RST;
         active_ff    <= ACTIVE_CH_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_PHASE_INC: phase_inc_ff <= csr_wdata;
            CSR_DEPTH:     depth_ff     <= csr_wdata[18:0];
            CSR_BASE:      base_ff      <= csr_wdata;
            CSR_MIX:       mix_ff       <= csr_wdata[15:0];
            CSR_ACTIVE_CH: active_ff    <= csr_wdata[1:0];
            default: begin
            end
         endcase
      end
   end

   // Sine table, built at elaboration
   logic signed [15:0] sine_rom [SINE_ENTRIES];
   for (genvar k = 0; k < SINE_ENTRIES; k++) begin : g_sine
      localparam logic [31:0] UK = 32'((64'(k) << 32) / SINE_ENTRIES);
      assign sine_rom[k] = sine_q15(UK);
   end

   logic [3:0]         state_ff;
   logic [AW:0]        clr_ff;
   logic [31:0]        phase_ff;
   logic [IW-1:0]      wp_ff;
   tvc_frame_type      x_ff;
   logic [1:0]         nch_ff;
   logic [15:0]        wet_ff;
   logic [15:0]        dry_ff;
   logic signed [15:0] lfo_ff [2];
   logic signed [35:0] prod_ff;
   logic [DW-1:0]      d_ff [2];
   logic [IW-1:0]      i_ff [2];
   logic [IW-1:0]      inext_ff [2];
   logic [7:0]         t_ff [2];
   logic               ch_ff;
   logic [2:0]         rd_cnt_ff;
   logic [8:0]         wt_ff;
   logic signed [34:0] acc_ff;
   logic signed [40:0] p1_ff;
   logic signed [51:0] p2_ff;
   logic signed [23:0] y_ff [2];
   logic               out_valid_ff;
   logic [47:0]        out_data_ff;

   // Delay line memory
   logic [23:0]        mem [TOTAL];
   logic [23:0]        rd_data_ff;
   logic               mem_we;
   logic [AW-1:0]      mem_waddr;
   logic [23:0]        mem_wdata;
   logic [AW-1:0]      mem_raddr;

   // LFO table index
   logic [31:0]        phase1;
   logic [KPW-1:0]     kp0;
   logic [KPW-1:0]     kp1;
   logic [SIW-1:0]     k0;
   logic [SIW-1:0]     k1;

   assign phase1 = phase_ff + 32'h4000_0000;
   assign kp0    = KPW'(phase_ff) * KPW'(SINE_ENTRIES);
   assign kp1    = KPW'(phase1) * KPW'(SINE_ENTRIES);
   assign k0     = kp0[32 +: SIW];
   assign k1     = kp1[32 +: SIW];

   // Tap delay: base plus half depth times LFO, clamped
   logic signed [23:0] dsum;
   logic [DW-1:0]      d_in;
   logic signed [35:0] prod_in;
   logic               lfo_sel;

   assign lfo_sel = (state_ff == S_D0);
   assign prod_in = $signed({1'b0, depth_ff}) * (lfo_sel ? lfo_ff[1] : lfo_ff[0]);
   assign dsum    = $signed({4'd0, base_ff}) + $signed({{4{prod_ff[35]}}, prod_ff[35:16]});

   always_comb begin
      priority if (dsum < D_MIN) begin
         d_in = DW'(D_MIN);
      end else if (dsum > D_MAX) begin
         d_in = DW'(D_MAX);
      end else begin
         d_in = DW'(dsum);
      end
   end

   // Read points of both taps
   logic [RW-1:0] r_raw [2];
   logic [RW-1:0] r_in [2];

   always_comb begin
      for (int j = 0; j < 2; j++) begin
         r_raw[j] = RW'({wp_ff, 8'h00}) + SPAN - RW'(d_ff[j]);
         r_in[j]  = (r_raw[j] >= SPAN) ? (r_raw[j] - SPAN) : r_raw[j];
      end
   end

   // Read sequencing: tap then neighbor, for both taps
   logic               rd_tap;
   logic               rd_next;
   logic [IW-1:0]      rd_index;
   logic [8:0]         wt_in;
   logic signed [33:0] mac;
   logic               processed;

   assign rd_tap    = rd_cnt_ff[1];
   assign rd_next   = rd_cnt_ff[0];
   assign rd_index  = rd_next ? inext_ff[rd_tap] : i_ff[rd_tap];
   assign wt_in     = rd_next ? {1'b0, t_ff[rd_tap]} : (9'd256 - {1'b0, t_ff[rd_tap]});
   assign mac       = $signed(rd_data_ff) * $signed({1'b0, wt_ff});
   assign processed = ({1'b0, ch_ff} < nch_ff);
   assign mem_raddr = (ch_ff ? CH1_BASE : AW'(0)) + AW'(rd_index);

   // Mix, round and saturate; channels not active pass through unchanged
   logic signed [23:0] x_cur;
   logic signed [53:0] mix_sum;
   logic signed [29:0] y_wide;
   logic signed [23:0] y_in;

   assign x_cur   = ch_ff ? x_ff.sample_ch1 : x_ff.sample_ch0;
   assign mix_sum = (54'(p1_ff) <<< 9) + 54'(p2_ff) + 54'sd8388608;
   assign y_wide  = mix_sum[53:24];

   always_comb begin
      priority if (!processed) begin
         y_in = x_cur;
      end else if (y_wide > 30'sd8388607) begin
         y_in = 24'sh7FFFFF;
      end else if (y_wide < -30'sd8388608) begin
         y_in = 24'sh800000;
      end else begin
         y_in = y_wide[23:0];
      end
   end

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = (ch_ff ? CH1_BASE : AW'(0)) + AW'(wp_ff);
      mem_wdata = x_cur;
      if (state_ff == S_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = clr_ff[AW-1:0];
         mem_wdata = 24'd0;
      end else if ((state_ff == S_WR) && processed) begin
         mem_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[mem_raddr];
   end

   logic pop;
   logic load_out;

   assign pop      = (state_ff == S_IDLE) && queue_head.valid;
   assign load_out = (state_ff == S_DONE) && (!out_valid_ff || rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         phase_ff     <= 32'd0;
         wp_ff        <= '0;
         ch_ff        <= 1'b0;
         rd_cnt_ff    <= 3'd0;
         out_valid_ff <= 1'b0;
      end else begin
         if (load_out) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == CLR_LAST) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (pop) begin
                  state_ff <= S_LFO;
               end
            end
            S_LFO:  state_ff <= S_D0;
            S_D0:   state_ff <= S_D1;
            S_D1: begin
               ch_ff    <= 1'b0;
               state_ff <= S_ADDR;
            end
            S_ADDR: state_ff <= S_CH;
            S_CH: begin
               rd_cnt_ff <= 3'd0;
               state_ff  <= processed ? S_RD : S_WR;
            end
            S_RD: begin
               rd_cnt_ff <= rd_cnt_ff + 3'd1;
               if (rd_cnt_ff == 3'd4) begin
                  state_ff <= S_MIX1;
               end
            end
            S_MIX1: state_ff <= S_MIX2;
            S_MIX2: state_ff <= S_WR;
            S_WR: begin
               if (ch_ff) begin
                  state_ff <= S_DONE;
               end else begin
                  ch_ff    <= 1'b1;
                  state_ff <= S_CH;
               end
            end
            S_DONE: begin
               if (load_out) begin
                  wp_ff        <= (wp_ff == I_LAST) ? '0 : wp_ff + 1'b1;
                  phase_ff     <= phase_ff + {12'd0, phase_inc_ff};
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // Datapath registers, no reset
   always_ff @(posedge clock) begin
      if (pop) begin
         x_ff      <= queue_head.frame;
         lfo_ff[0] <= sine_rom[k0];
         lfo_ff[1] <= sine_rom[k1];
         nch_ff    <= (active_ff > NCH_MAX) ? NCH_MAX : active_ff;
         wet_ff    <= (mix_ff > MIX_ONE) ? MIX_ONE : mix_ff;
         dry_ff    <= MIX_ONE - ((mix_ff > MIX_ONE) ? MIX_ONE : mix_ff);
      end
      if ((state_ff == S_LFO) || (state_ff == S_D0)) begin
         prod_ff <= prod_in;
      end
      if (state_ff == S_D0) begin
         d_ff[0] <= d_in;
      end
      if (state_ff == S_D1) begin
         d_ff[1] <= d_in;
      end
      if (state_ff == S_ADDR) begin
         for (int j = 0; j < 2; j++) begin
            i_ff[j]     <= r_in[j][DW-1:8];
            t_ff[j]     <= r_in[j][7:0];
            inext_ff[j] <= (r_in[j][DW-1:8] == I_LAST) ? '0 : r_in[j][DW-1:8] + 1'b1;
         end
      end
      if (state_ff == S_CH) begin
         acc_ff <= '0;
      end
      if (state_ff == S_RD) begin
         wt_ff <= wt_in;
         if (rd_cnt_ff != 3'd0) begin
            acc_ff <= acc_ff + 35'(mac);
         end
      end
      if (state_ff == S_MIX1) begin
         p1_ff <= $signed({1'b0, dry_ff}) * x_cur;
      end
      if (state_ff == S_MIX2) begin
         p2_ff <= $signed({1'b0, wet_ff}) * acc_ff;
      end
      if (state_ff == S_WR) begin
         y_ff[ch_ff] <= y_in;
      end
      if (load_out) begin
         out_data_ff <= {y_ff[1], y_ff[0]};
      end
   end

   assign back_status.clearing = (state_ff == S_CLEAR);
   assign back_status.pop      = pop;
   assign rsp_tvalid           = out_valid_ff;
   assign rsp_tdata            = out_data_ff;

   a_no_pop_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !pop)
      else $error("frame taken during clearing pass");

   a_rd_cnt_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RD) |-> (rd_cnt_ff <= 3'd4))
      else $error("read counter out of range");

   a_delay_clamped: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_D1) |=> ((d_ff[0] >= DW'(D_MIN)) && (d_ff[0] <= DW'(D_MAX))
                             && (d_ff[1] >= DW'(D_MIN)) && (d_ff[1] <= DW'(D_MAX))))
      else $error("tap delay outside clamp");

   a_done_loads: assert property (@(posedge clock) disable iff (reset)
      load_out |=> (rsp_tvalid && (state_ff == S_IDLE)))
      else $error("finished frame not presented");

endmodule

// ===== sv/two_voice_chorus_unit.sv =====
// Two-voice chorus on stereo frames of signed 24-bit samples.
// Input channel (req_*): one transaction carries one frame, sample_ch0 in
// req_tdata[23:0] and sample_ch1 in req_tdata[47:24]. Result channel (rsp_*):
// one transaction per input frame, out_ch0 / out_ch1 packed the same way,
// in input order.
// Configuration (csr_*): write csr_wdata to register csr_index while the unit
// is idle; indexes 0..4 are phase increment, depth, base delay, mix level
// and active channel count. Other indexes are ignored.
// Sequencing: one frame at a time through a single sequencer sharing one
// delay-line memory port: four interpolation reads per active channel at
// one read per cycle, then two mix multiplies. A two-frame queue keeps
// accepting while the sequencer works.
// Reset: synchronous, active high. After reset a clearing pass zeroes all
// DELAY_DEPTH*CHANNELS delay-line words (8192 at defaults); req_tready
// stays low meanwhile. When rsp_tready is low the finished frame holds in
// the output register and the sequencer waits before the next frame.
module two_voice_chorus_unit import tvc_pkg::*; #(
   parameter int DELAY_DEPTH  = 4096,
   parameter int CHANNELS     = 2,
   parameter int SINE_ENTRIES = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // sample_ch0 [23:0], sample_ch1 [47:24]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // out_ch0 [23:0], out_ch1 [47:24]
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [19:0] csr_wdata
);

   tvc_queue_type       queue_head;
   tvc_back_status_type back_status;

   // Front: accept transactions into the frame queue
   tvc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .back_status (back_status),
      .queue_head  (queue_head)
   );

   // Back: LFO, tap delays, interpolation reads, mix and output register
   tvc_back #(
      .DELAY_DEPTH  (DELAY_DEPTH),
      .CHANNELS     (CHANNELS),
      .SINE_ENTRIES (SINE_ENTRIES)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .queue_head  (queue_head),
      .back_status (back_status),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top import tvc_pkg::*; ();

   // Indexes with no register behind them; writes there must change nothing
   localparam logic [2:0] CSR_SPARE_LO = 3'd5;
   localparam logic [2:0] CSR_SPARE_HI = 3'd7;

   localparam int LINE_LEN   = 4096;
   localparam int LUT_LEN    = 256;
   localparam int HOLD_CYCLES = 600;
   localparam int DRAIN_CYCLES = 60;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;   // sample_ch0 [23:0], sample_ch1 [47:24]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;        // out_ch0 [23:0], out_ch1 [47:24]
   logic        csr_wr_en = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [19:0] csr_wdata = '0;

   two_voice_chorus_unit dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #40000000;
      $display("Regression FAIL");
      $finish;
   end

   // ---------------------------------------------------------------
   // Chorus predictor: own copy of registers, delay lines and LFO
   // ---------------------------------------------------------------
   logic [19:0] r_inc;
   logic [18:0] r_depth;
   logic [19:0] r_base;
   logic [15:0] r_mix;
   logic [1:0]  r_active;
   logic [11:0] wr_pos;
   logic [31:0] lfo_ph;
   int          line_mem [2][LINE_LEN];
   int          sine_lut [LUT_LEN];

   typedef struct {
      logic [23:0] out0;
      logic [23:0] out1;
   } out_frame_type;

   out_frame_type expected_frames [$];

   int errors = 0;
   int frames_sent = 0;
   int frames_seen = 0;
   int cfg_writes = 0;

   // Q15 sine of table entry k: fold to first quadrant, Taylor series in Q30
   function automatic int sine_entry(int k);
      logic [31:0]       ang;
      longint unsigned   rr, aa, xx, x2, tt, ss, vv;
      ang = 32'(k) << 24;
      rr  = longint'(ang[29:0]);
      aa  = ang[30] ? ((64'd1 << 30) - rr) : rr;
      xx  = (aa * 64'd1686629713) >> 30;
      x2  = (xx * xx) >> 30;
      tt  = (64'd1 << 30) - x2 / 110;
      tt  = (64'd1 << 30) - ((x2 * tt) >> 30) / 72;
      tt  = (64'd1 << 30) - ((x2 * tt) >> 30) / 42;
      tt  = (64'd1 << 30) - ((x2 * tt) >> 30) / 20;
      tt  = (64'd1 << 30) - ((x2 * tt) >> 30) / 6;
      ss  = (xx * tt) >> 30;
      vv  = (ss + 16384) >> 15;
      if (vv > 32767) begin
         vv = 32767;
      end
      return ang[31] ? -int'(vv) : int'(vv);
   endfunction

   // Tap delay in 1/256 sample, held between one sample and one sample short of the line length
   function automatic longint tap_len(int lfo);
      longint prod, d;
      prod = longint'(r_depth) * longint'(lfo);
      d    = longint'(r_base) + (prod >>> 16);
      if (d < 256) d = 256;
      if (d > longint'(LINE_LEN - 1) * 256) d = longint'(LINE_LEN - 1) * 256;
      return d;
   endfunction

   // Linear interpolation between two neighbors, result kept in Q8
   function automatic longint tap_read(int c, longint d);
      longint span, rp, frac;
      int     idx;
      span = longint'(LINE_LEN) * 256;
      rp   = (longint'(wr_pos) * 256 + span - d) % span;
      idx  = int'(rp >>> 8);
      frac = rp & 255;
      return longint'(line_mem[c][idx]) * (256 - frac)
           + longint'(line_mem[c][(idx + 1) % LINE_LEN]) * frac;
   endfunction

   task automatic chorus_frame(input logic [23:0] a, input logic [23:0] b,
                               output out_frame_type res);
      int          nch;
      longint      wet, dry, d0, d1, xv, yv, acc;
      logic [23:0] ins [2];
      logic [23:0] outs [2];
      ins[0] = a;
      ins[1] = b;
      nch = (r_active > 2) ? 2 : int'(r_active);
      wet = (r_mix > MIX_ONE) ? 32768 : longint'(r_mix);
      dry = 32768 - wet;
      d0  = tap_len(sine_lut[lfo_ph[31:24]]);
      d1  = tap_len(sine_lut[8'(lfo_ph[31:24] + 8'd64)]);
      for (int c = 0; c < 2; c++) begin
         xv = longint'($signed(ins[c]));
         yv = xv;
         if (c < nch) begin
            acc = dry * xv * 512 + wet * (tap_read(c, d0) + tap_read(c, d1));
            yv  = (acc + (64'sd1 <<< 23)) >>> 24;
            if (yv > 8388607) yv = 8388607;
            if (yv < -8388608) yv = -8388608;
            line_mem[c][wr_pos] = int'(xv);
         end
         outs[c] = yv[23:0];
      end
      res.out0 = outs[0];
      res.out1 = outs[1];
      wr_pos = wr_pos + 12'd1;
      lfo_ph = lfo_ph + 32'(r_inc);
   endtask

   // ---------------------------------------------------------------
   // Result side: check each transaction, drive rsp_tready
   // ---------------------------------------------------------------
   int  recv_idle_pct = 60;
   int  send_idle_pct = 8;
   bit  hold_ask = 1'b0;
   bit  held_once = 1'b0;
   int  hold_left = 0;

   task automatic report_mismatch(string what, logic [23:0] got, logic [23:0] want);
      errors++;
      $display("mismatch frame %0d %s: got %h want %h", frames_seen, what, got, want);
   endtask

   always @(posedge clock) begin
      out_frame_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_frames.size() == 0) begin
               errors++;
               $display("unexpected result transaction %h", rsp_tdata);
            end else begin
               want = expected_frames.pop_front();
               if (rsp_tdata[23:0] !== want.out0)
                  report_mismatch("out_ch0", rsp_tdata[23:0], want.out0);
               if (rsp_tdata[47:24] !== want.out1)
                  report_mismatch("out_ch1", rsp_tdata[47:24], want.out1);
            end
            frames_seen++;
         end
         // Hold off once for a long stretch so the input side backs up
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (hold_ask && !held_once) begin
            held_once = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // ---------------------------------------------------------------
   // Input side
   // ---------------------------------------------------------------
   bit offering = 1'b0;

   // Offer one frame, hold it until accepted, then predict it
   task automatic send_frame(logic [23:0] a, logic [23:0] b,
                             bit fixed = 1'b0, logic [23:0] ea = '0,
                             logic [23:0] eb = '0);
      out_frame_type res;
      req_tvalid <= 1'b1;
      req_tdata  <= {b, a};
      offering = 1'b1;
      do @(posedge clock); while (!req_tready);
      chorus_frame(a, b, res);
      if (fixed) begin
         res.out0 = ea;
         res.out1 = eb;
      end
      expected_frames.push_back(res);
      frames_sent++;
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         offering = 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // Drain everything, let the sequencer settle, then write one register
   task automatic write_reg(logic [2:0] idx, logic [19:0] val);
      if (offering) begin
         req_tvalid <= 1'b0;
         offering = 1'b0;
      end
      while (expected_frames.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_PHASE_INC: r_inc    = val;
         CSR_DEPTH:     r_depth  = val[18:0];
         CSR_BASE:      r_base   = val;
         CSR_MIX:       r_mix    = val[15:0];
         CSR_ACTIVE_CH: r_active = val[1:0];
         default: ;
      endcase
      cfg_writes++;
   endtask

   typedef struct {
      bit          wr;
      logic [2:0]  idx;
      logic [19:0] val;
      logic [23:0] a;
      logic [23:0] b;
      bit          fixed;
      logic [23:0] ea;
      logic [23:0] eb;
   } stim_row_type;

   // Directed part: a write row changes a register, a frame row sends one
   // frame; fixed rows carry their expected output
   stim_row_type directed [] = '{
      '{1, CSR_MIX,       20'd0,      0, 0, 0, 0, 0},
      '{0, 0, 0, 24'h000000, 24'h000000, 1, 24'h000000, 24'h000000},
      '{0, 0, 0, 24'h7FFFFF, 24'h800000, 1, 24'h7FFFFF, 24'h800000},
      '{0, 0, 0, 24'h800000, 24'h7FFFFF, 1, 24'h800000, 24'h7FFFFF},
      '{0, 0, 0, 24'h000001, 24'hFFFFFF, 1, 24'h000001, 24'hFFFFFF},
      '{1, CSR_MIX,       20'd11469,  0, 0, 0, 0, 0},
      '{1, CSR_ACTIVE_CH, 20'd0,      0, 0, 0, 0, 0},
      '{0, 0, 0, 24'h7FFFFF, 24'h800000, 1, 24'h7FFFFF, 24'h800000},
      '{0, 0, 0, 24'h123456, 24'hABCDEF, 1, 24'h123456, 24'hABCDEF},
      '{1, CSR_ACTIVE_CH, 20'd3,      0, 0, 0, 0, 0},
      '{1, CSR_MIX,       20'hFFFFF,  0, 0, 0, 0, 0},
      '{1, CSR_BASE,      20'd0,      0, 0, 0, 0, 0},
      '{1, CSR_DEPTH,     20'd0,      0, 0, 0, 0, 0},
      '{0, 0, 0, 24'h7FFFFF, 24'h800000, 0, 0, 0},
      '{0, 0, 0, 24'h800000, 24'h7FFFFF, 0, 0, 0},
      '{1, CSR_BASE,      20'hFFFFF,  0, 0, 0, 0, 0},
      '{1, CSR_DEPTH,     20'h7FFFF,  0, 0, 0, 0, 0},
      '{1, CSR_PHASE_INC, 20'hFFFFF,  0, 0, 0, 0, 0},
      '{0, 0, 0, 24'h400000, 24'hC00000, 0, 0, 0},
      '{0, 0, 0, 24'h7FFFFF, 24'h7FFFFF, 0, 0, 0},
      '{1, CSR_ACTIVE_CH, 20'd1,      0, 0, 0, 0, 0},
      '{1, CSR_SPARE_LO,  20'hAAAAA,  0, 0, 0, 0, 0},
      '{1, CSR_SPARE_HI,  20'h55555,  0, 0, 0, 0, 0},
      '{0, 0, 0, 24'h800000, 24'h800000, 0, 0, 0},
      '{0, 0, 0, 24'h555555, 24'hAAAAAA, 0, 0, 0}
   };

   function automatic logic [23:0] pick_sample();
      case ($urandom_range(9))
         0: return $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
         1: return 24'($signed($urandom_range(200)) - 100);
         default: return 24'($urandom);
      endcase
   endfunction

   // Register values: each either a chosen value or anything the port holds
   task automatic pick_settings();
      write_reg(CSR_PHASE_INC, ($urandom_range(2) == 0) ? 20'(($urandom_range(1)) ? 20'hFFFFF : 0)
                                                        : 20'($urandom));
      write_reg(CSR_DEPTH, ($urandom_range(2) == 0) ? 20'd368640 : 20'($urandom));
      write_reg(CSR_BASE, ($urandom_range(3) == 0) ? 20'd614400
                        : ($urandom_range(2) == 0) ? 20'($urandom_range(2000)) : 20'($urandom));
      write_reg(CSR_MIX, ($urandom_range(3) == 0) ? 20'd32768 : 20'($urandom));
      write_reg(CSR_ACTIVE_CH, ($urandom_range(3) == 0) ? 20'($urandom) : 20'd2);
      if ($urandom_range(2) == 0)
         write_reg(CSR_SPARE_LO + 3'($urandom_range(2)), 20'($urandom));
   endtask

   initial begin
      for (int k = 0; k < LUT_LEN; k++) sine_lut[k] = sine_entry(k);
      foreach (line_mem[c, i]) line_mem[c][i] = 0;
      r_inc    = PHASE_INC_RST;
      r_depth  = DEPTH_RST;
      r_base   = BASE_RST;
      r_mix    = MIX_RST;
      r_active = ACTIVE_CH_RST;
      wr_pos   = '0;
      lfo_ph   = '0;

      // Hold reset, then drop it at a rising edge
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // A few frames on reset settings first (waits out the clearing pass)
      for (int n = 0; n < 3; n++) send_frame(pick_sample(), pick_sample());

      foreach (directed[r]) begin
         if (directed[r].wr)
            write_reg(directed[r].idx, directed[r].val);
         else
            send_frame(directed[r].a, directed[r].b, directed[r].fixed,
                       directed[r].ea, directed[r].eb);
      end

      // Random part in three eras: sender rarely idle, receiver rarely
      // idle, then no idling at all
      for (int n = 0; n < 750; n++) begin
         if (n == 250) begin
            send_idle_pct = 60;
            recv_idle_pct = 8;
         end
         if (n == 500) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if (n % 75 == 0) pick_settings();
         if (n == 520) hold_ask = 1'b1;
         send_frame(pick_sample(), pick_sample());
      end

      if (offering) begin
         req_tvalid <= 1'b0;
         offering = 1'b0;
      end
      while (expected_frames.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d frames over %0d register writes, with extremes, clamps,",
               frames_sent, cfg_writes);
      $display("passthrough, idling on both sides and one long output stall.");
      if (errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ===== two_voice_chorus_unit.f =====
sv/tvc_pkg.sv
sv/tvc_front.sv
sv/tvc_back.sv
sv/two_voice_chorus_unit.sv
verif/tb_top.sv
